// ===== hw/rtl/swrs_pkg.sv =====
// shared types and constants for the sliding window range spread block
package swrs_pkg;

  // default build values
  localparam int MaxHalfDef  = 31;
  localparam int FracBitsDef = 8;

  // fixed field and state widths, limits and reset value
  localparam int SampleW     = 16;
  localparam int HalfW       = 5;
  localparam int FracW       = 8;
  localparam int CfgW        = 8;
  localparam int CfgIdxW     = 1;
  localparam int RangeW      = 24;
  localparam int GapW        = 15;
  localparam int CntW        = 7;
  localparam int CiW         = 6;
  localparam int MaxPend     = 31;
  localparam int QDepth      = 2;
  localparam int HalfWidthRst = 1;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HALF_WIDTH = 1'b0,
    CFG_FRAC_PART  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      frame_last;
  } item_t;

  typedef struct packed {
    logic [RangeW-1:0] range_value;
    logic [GapW-1:0]   position_gap;
    logic              result_last;
  } result_t;

  typedef struct packed {
    logic [HalfW-1:0] half_width;
    logic [FracW-1:0] frac_part;
  } cfg_t;

  // classified item handed from the front end to the back end
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic [CntW-1:0]           rcv_count;
    logic                      frame_last;
  } job_t;

  // back end sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_LEFT_A,
    ST_LEFT_B,
    ST_RIGHT_A,
    ST_RIGHT_B,
    ST_END,
    ST_DRAIN
  } run_state_e;

  // kind of a read travelling down the compare pipeline
  typedef enum logic [1:0] {
    TAG_WIN,
    TAG_IA,
    TAG_IB,
    TAG_END
  } tag_e;

endpackage

// ===== hw/rtl/swrs_front.sv =====
// front end: accepts items, counts samples of the frame, builds jobs
module swrs_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  swrs_pkg::item_t in_data_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output swrs_pkg::job_t  job_o
);

  logic [swrs_pkg::CntW-1:0] rcv_q, rcv_d, rcv_inc;
  logic                      accept;

  // handshake passes straight to the queue
  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign accept      = in_valid_i && job_ready_i;

  // saturating count of samples received in this frame
  assign rcv_inc = (rcv_q == '1) ? rcv_q : rcv_q + 1'b1;

  // job carries the sample, its count and the frame end mark
  always_comb begin
    job_o.sample     = in_data_i.sample;
    job_o.rcv_count  = rcv_inc;
    job_o.frame_last = in_data_i.frame_last;
  end

  // count restarts after the frame's last item
  always_comb begin
    rcv_d = rcv_q;
    if (accept) begin
      rcv_d = in_data_i.frame_last ? '0 : rcv_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_q <= '0;
    end else begin
      rcv_q <= rcv_d;
    end
  end

endmodule

// ===== hw/rtl/swrs_queue.sv =====
// small job queue between front end and back end
module swrs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  swrs_pkg::job_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output swrs_pkg::job_t pop_data_o
);

  localparam int IdxW = (swrs_pkg::QDepth > 1) ? $clog2(swrs_pkg::QDepth) : 1;
  localparam int FillW = $clog2(swrs_pkg::QDepth + 1);

  swrs_pkg::job_t   slot_q [swrs_pkg::QDepth];
  logic [IdxW-1:0]  wr_q, rd_q;
  logic [FillW-1:0] fill_q;
  logic             push, pop;

  assign push_ready_o = (fill_q != FillW'(swrs_pkg::QDepth));
  assign pop_valid_o  = (fill_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_q];

  // storage slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == IdxW'(swrs_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == IdxW'(swrs_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/swrs_back.sv =====
// back end: delay line memory, window scan sequencer and min/max compare pipeline
module swrs_back #(
  parameter int MAX_HALF  = swrs_pkg::MaxHalfDef,
  parameter int FRAC_BITS = swrs_pkg::FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  swrs_pkg::cfg_t    cfg_i,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  swrs_pkg::job_t    job_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output swrs_pkg::result_t out_data_o,
  output logic              pend_empty_o
);

  localparam int Depth      = 2 * MAX_HALF + 3;
  localparam int AW         = $clog2(Depth);
  localparam int MemDepth   = 2 ** AW;
  localparam int LW         = swrs_pkg::CntW;
  localparam int CiW        = swrs_pkg::CiW;
  localparam int SW         = swrs_pkg::SampleW;
  localparam int MaxPendEff = (MAX_HALF + 1 > swrs_pkg::MaxPend) ? swrs_pkg::MaxPend
                                                                 : MAX_HALF + 1;
  localparam int KW         = $clog2(MAX_HALF + 1) + 1;
  localparam int VW         = FRAC_BITS + 18;
  localparam int PW         = FRAC_BITS + 8;
  localparam int RXW        = (VW > swrs_pkg::RangeW) ? VW : swrs_pkg::RangeW + 1;
  localparam int GXW        = (PW > swrs_pkg::GapW) ? PW : swrs_pkg::GapW + 1;
  localparam int RangeMax   = 2 ** swrs_pkg::RangeW - 1;
  localparam int GapMax     = 2 ** swrs_pkg::GapW - 1;

  // effective configuration
  logic [swrs_pkg::HalfW-1:0]           h_eff;
  logic [FRAC_BITS+swrs_pkg::FracW-1:0] frac_ext;
  logic [FRAC_BITS-1:0]                 f_eff;
  logic                                 f_nz;
  logic [CiW-1:0]                       dly_raw, dly;
  logic [LW-1:0]                        h_w;
  logic signed [PW-1:0]                 off;

  // sequencer state
  swrs_pkg::run_state_e st_q, st_d;
  logic [AW-1:0]        ptr_q, ptr_d;
  logic [CiW-1:0]       ci_q, ci_d;
  logic [LW-1:0]        rcv_q, rcv_d;
  logic                 flast_q, flast_d;
  logic [LW-1:0]        lag_q, lag_d, idx_q, idx_d, rem_q, rem_d;
  logic signed [KW-1:0] k_q, k_d;
  logic                 use_l_q, use_l_d, use_r_q, use_r_d, em_last_q, em_last_d;

  // emission setup
  logic [LW-1:0] lag_w, left_w, lo_w, hi_w;
  logic          emit_w;

  // read issue
  logic                 iss_vld;
  swrs_pkg::tag_e       iss_kind;
  logic [LW-1:0]        iss_idx;
  logic signed [PW-1:0] iss_pos;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 mem_we;

  // memory and compare pipeline
  logic signed [SW-1:0]  mem_q [MemDepth];
  logic signed [SW-1:0]  rdata_q, a_q, base_src;
  logic                  s1_vld_q, s2_vld_q;
  swrs_pkg::tag_e        s1_kind_q, s2_kind_q;
  logic signed [PW-1:0]  s1_pos_q, s2_pos_q;
  logic signed [SW:0]    diff_w;
  logic signed [FRAC_BITS:0] f_sgn;
  logic signed [VW-1:0]  prod_w, base_w, s2_base_q, s2_prod_q, v_w;
  logic signed [VW-1:0]  mn_q, mx_q;
  logic signed [PW-1:0]  pmn_q, pmx_q;
  logic                  first_q, lt_w, gt_w, res_done;

  // result formatting
  logic [VW-1:0]        rng_w;
  logic [RXW-1:0]       rng_x;
  logic signed [PW-1:0] gd_w;
  logic [PW-1:0]        ga_w;
  logic [GXW-1:0]       gap_x;
  logic                 out_valid_q;
  swrs_pkg::result_t    out_q;

  // configuration decode
  assign h_eff    = (cfg_i.half_width > swrs_pkg::HalfW'(MAX_HALF))
                    ? swrs_pkg::HalfW'(MAX_HALF) : cfg_i.half_width;
  assign frac_ext = (FRAC_BITS + swrs_pkg::FracW)'(cfg_i.frac_part);
  assign f_eff    = frac_ext[FRAC_BITS-1:0];
  assign f_nz     = (f_eff != '0);
  assign dly_raw  = CiW'(h_eff) + CiW'(f_nz);
  assign dly      = (dly_raw > CiW'(MaxPendEff)) ? CiW'(MaxPendEff) : dly_raw;
  assign h_w      = LW'(h_eff);
  assign off      = (PW'(h_eff) << FRAC_BITS) | PW'(f_eff);

  // window limits for the oldest pending sample
  assign lag_w  = LW'(ci_q) - LW'(1);
  assign left_w = (rcv_q > lag_w) ? rcv_q - LW'(1) - lag_w : '0;
  assign lo_w   = (h_w < left_w) ? h_w : left_w;
  assign hi_w   = (h_w < lag_w) ? h_w : lag_w;
  assign emit_w = flast_q ? (ci_q != '0) : (ci_q > dly);

  assign res_done = s2_vld_q && (s2_kind_q == swrs_pkg::TAG_END);

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      swrs_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          st_d = swrs_pkg::ST_CHECK;
        end
      end
      swrs_pkg::ST_CHECK: begin
        st_d = emit_w ? swrs_pkg::ST_SCAN : swrs_pkg::ST_IDLE;
      end
      swrs_pkg::ST_SCAN: begin
        if (rem_q == '0) begin
          if (use_l_q) begin
            st_d = swrs_pkg::ST_LEFT_A;
          end else if (use_r_q) begin
            st_d = swrs_pkg::ST_RIGHT_A;
          end else begin
            st_d = swrs_pkg::ST_END;
          end
        end
      end
      swrs_pkg::ST_LEFT_A: st_d = swrs_pkg::ST_LEFT_B;
      swrs_pkg::ST_LEFT_B: begin
        st_d = use_r_q ? swrs_pkg::ST_RIGHT_A : swrs_pkg::ST_END;
      end
      swrs_pkg::ST_RIGHT_A: st_d = swrs_pkg::ST_RIGHT_B;
      swrs_pkg::ST_RIGHT_B: st_d = swrs_pkg::ST_END;
      swrs_pkg::ST_END: begin
        if (!out_valid_q) begin
          st_d = swrs_pkg::ST_DRAIN;
        end
      end
      swrs_pkg::ST_DRAIN: begin
        if (res_done) begin
          st_d = swrs_pkg::ST_CHECK;
        end
      end
      default: st_d = swrs_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: job pop and memory reads
  always_comb begin
    job_ready_o = 1'b0;
    iss_vld     = 1'b0;
    iss_kind    = swrs_pkg::TAG_WIN;
    iss_idx     = '0;
    iss_pos     = '0;
    unique case (st_q)
      swrs_pkg::ST_IDLE: job_ready_o = 1'b1;
      swrs_pkg::ST_SCAN: begin
        iss_vld = 1'b1;
        iss_idx = idx_q;
        iss_pos = PW'(k_q) <<< FRAC_BITS;
      end
      swrs_pkg::ST_LEFT_A: begin
        iss_vld  = 1'b1;
        iss_kind = swrs_pkg::TAG_IA;
        iss_idx  = lag_q + h_w;
      end
      swrs_pkg::ST_LEFT_B: begin
        iss_vld  = 1'b1;
        iss_kind = swrs_pkg::TAG_IB;
        iss_idx  = lag_q + h_w + LW'(1);
        iss_pos  = -off;
      end
      swrs_pkg::ST_RIGHT_A: begin
        iss_vld  = 1'b1;
        iss_kind = swrs_pkg::TAG_IA;
        iss_idx  = lag_q - h_w;
      end
      swrs_pkg::ST_RIGHT_B: begin
        iss_vld  = 1'b1;
        iss_kind = swrs_pkg::TAG_IB;
        iss_idx  = lag_q - h_w - LW'(1);
        iss_pos  = off;
      end
      swrs_pkg::ST_END: begin
        iss_vld  = !out_valid_q;
        iss_kind = swrs_pkg::TAG_END;
      end
      default: ;
    endcase
  end

  // sequencer registers: pending count, frame count, window walk
  always_comb begin
    ptr_d     = ptr_q;
    ci_d      = ci_q;
    rcv_d     = rcv_q;
    flast_d   = flast_q;
    lag_d     = lag_q;
    idx_d     = idx_q;
    rem_d     = rem_q;
    k_d       = k_q;
    use_l_d   = use_l_q;
    use_r_d   = use_r_q;
    em_last_d = em_last_q;
    case (st_q)
      swrs_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          ptr_d   = ptr_q + 1'b1;
          rcv_d   = job_i.rcv_count;
          flast_d = job_i.frame_last;
          ci_d    = (ci_q >= CiW'(MaxPendEff + 1)) ? ci_q : ci_q + 1'b1;
        end
      end
      swrs_pkg::ST_CHECK: begin
        if (emit_w) begin
          lag_d     = lag_w;
          idx_d     = lag_w + lo_w;
          rem_d     = lo_w + hi_w;
          k_d       = -$signed(KW'(lo_w));
          use_l_d   = f_nz && (h_w + LW'(1) <= left_w);
          use_r_d   = f_nz && (h_w + LW'(1) <= lag_w);
          em_last_d = flast_q && (ci_q == CiW'(1));
        end
      end
      swrs_pkg::ST_SCAN: begin
        idx_d = idx_q - LW'(1);
        rem_d = rem_q - LW'(1);
        k_d   = k_q + KW'(1);
      end
      swrs_pkg::ST_DRAIN: begin
        if (res_done) begin
          ci_d = ci_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= swrs_pkg::ST_IDLE;
      ptr_q   <= '0;
      ci_q    <= '0;
      rcv_q   <= '0;
      flast_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      ptr_q   <= ptr_d;
      ci_q    <= ci_d;
      rcv_q   <= rcv_d;
      flast_q <= flast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lag_q     <= lag_d;
    idx_q     <= idx_d;
    rem_q     <= rem_d;
    k_q       <= k_d;
    use_l_q   <= use_l_d;
    use_r_q   <= use_r_d;
    em_last_q <= em_last_d;
  end

  // delay line memory: one write and one registered read per cycle
  assign mem_we  = job_valid_i && job_ready_o;
  assign wr_addr = ptr_q + 1'b1;
  assign rd_addr = ptr_q - iss_idx[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= job_i.sample;
    end
    if (iss_vld) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // stage 1: latch interpolation base, multiply slope by fraction
  assign diff_w   = (SW + 1)'(rdata_q) - (SW + 1)'(a_q);
  assign f_sgn    = {1'b0, f_eff};
  assign prod_w   = VW'(diff_w) * VW'(f_sgn);
  assign base_src = (s1_kind_q == swrs_pkg::TAG_IB) ? a_q : rdata_q;
  assign base_w   = VW'(base_src) <<< FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= iss_vld;
      s2_vld_q <= s1_vld_q && (s1_kind_q != swrs_pkg::TAG_IA);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_kind_q <= iss_kind;
    s1_pos_q  <= iss_pos;
    if (s1_vld_q && (s1_kind_q == swrs_pkg::TAG_IA)) begin
      a_q <= rdata_q;
    end
    s2_kind_q <= s1_kind_q;
    s2_pos_q  <= s1_pos_q;
    s2_base_q <= base_w;
    s2_prod_q <= (s1_kind_q == swrs_pkg::TAG_IB) ? prod_w : '0;
  end

  // stage 2: point value and strict compares
  assign v_w  = s2_base_q + s2_prod_q;
  assign lt_w = (v_w < mn_q);
  assign gt_w = (v_w > mx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (s2_vld_q) begin
      first_q <= (s2_kind_q == swrs_pkg::TAG_END);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      unique case (s2_kind_q)
        swrs_pkg::TAG_WIN: begin
          if (first_q || lt_w) begin
            mn_q  <= v_w;
            pmn_q <= s2_pos_q;
          end
          if (first_q || gt_w) begin
            mx_q  <= v_w;
            pmx_q <= s2_pos_q;
          end
        end
        swrs_pkg::TAG_IB: begin
          if (lt_w) begin
            mn_q  <= v_w;
            pmn_q <= s2_pos_q;
          end else if (gt_w) begin
            mx_q  <= v_w;
            pmx_q <= s2_pos_q;
          end
        end
        default: ;
      endcase
    end
  end

  // range and position gap with saturation
  assign rng_w = mx_q - mn_q;
  assign rng_x = RXW'(rng_w);
  assign gd_w  = pmx_q - pmn_q;
  assign ga_w  = (gd_w < 0) ? -gd_w : gd_w;
  assign gap_x = GXW'(ga_w);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_done) begin
      out_q.range_value  <= (rng_x > RXW'(RangeMax)) ? swrs_pkg::RangeW'(RangeMax)
                                                     : rng_x[swrs_pkg::RangeW-1:0];
      out_q.position_gap <= (gap_x > GXW'(GapMax)) ? swrs_pkg::GapW'(GapMax)
                                                   : gap_x[swrs_pkg::GapW-1:0];
      out_q.result_last  <= em_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;
  assign pend_empty_o = (ci_q == '0);

endmodule

// ===== hw/rtl/sliding_window_range_spread.sv =====
// sliding window range spread top; a result leaves after the item that releases it is taken,
//   once the N samples of its clipped window and any interpolated points have been scanned
// the scan is paced by the single read port of the delay line memory: one sample per cycle
// the back end takes a new item only after it has computed every result that item releases;
//   at H=31 the right point drops out; the frame's last item releases every pending result
// reset: async, clears control, counts and config (half width 1, fraction 0); no memory sweep
module sliding_window_range_spread #(
  parameter int MAX_HALF  = swrs_pkg::MaxHalfDef,
  parameter int FRAC_BITS = swrs_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [swrs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [swrs_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  swrs_pkg::item_t              in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output swrs_pkg::result_t            out_data_o
);

  localparam int GapRaw   = 2 * (MAX_HALF * (2 ** FRAC_BITS) + (2 ** FRAC_BITS) - 1);
  localparam int GapSat   = 2 ** swrs_pkg::GapW - 1;
  localparam int GapBound = (GapRaw > GapSat) ? GapSat : GapRaw;

  swrs_pkg::cfg_t cfg_q;
  logic           fj_valid, fj_ready, bj_valid, bj_ready, pend_empty;
  swrs_pkg::job_t fj_data, bj_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_width <= swrs_pkg::HalfW'(swrs_pkg::HalfWidthRst);
      cfg_q.frac_part  <= '0;
    end else if (cfg_we_i) begin
      unique case (swrs_pkg::cfg_idx_e'(cfg_idx_i))
        swrs_pkg::CFG_HALF_WIDTH: cfg_q.half_width <= cfg_data_i[swrs_pkg::HalfW-1:0];
        swrs_pkg::CFG_FRAC_PART:  cfg_q.frac_part  <= cfg_data_i[swrs_pkg::FracW-1:0];
        default: ;
      endcase
    end
  end

  // item intake
  swrs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (fj_valid),
    .job_ready_i (fj_ready),
    .job_o       (fj_data)
  );

  // job queue
  swrs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fj_valid),
    .push_ready_o (fj_ready),
    .push_data_i  (fj_data),
    .pop_valid_o  (bj_valid),
    .pop_ready_i  (bj_ready),
    .pop_data_o   (bj_data)
  );

  // window scan and result
  swrs_back #(
    .MAX_HALF  (MAX_HALF),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .job_valid_i  (bj_valid),
    .job_ready_o  (bj_ready),
    .job_i        (bj_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .pend_empty_o (pend_empty)
  );

  // positions never lie further apart than the widest window allows
  a_gap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_data_o.position_gap) <= GapBound))
    else $error("position gap beyond window width");

  // flat window keeps the first point for both extremes
  a_flat_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.range_value == '0)) |-> (out_data_o.position_gap == '0))
    else $error("zero range with nonzero gap");

  // frame end result only once nothing is left pending
  a_last_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_o) && out_data_o.result_last) |-> pend_empty)
    else $error("frame end result while samples still pending");

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the sliding window range spread block: random frames checked against a predictor
`timescale 1ns / 1ps

module tb;
  import swrs_pkg::*;

  localparam int Depth        = 2 * MaxHalfDef + 3;
  localparam int PendCap      = MaxPend;
  localparam int CountCap     = 127;
  localparam int SettleCycles = 300;
  localparam int CycleLimit   = 5_000_000;

  logic    clk_i        = 1'b0;
  logic    rst_ni       = 1'b0;
  logic    cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic    in_valid_i   = 1'b0;
  logic    in_ready_o;
  item_t   in_data_i    = '0;
  logic    out_valid_o;
  logic    out_ready_i  = 1'b0;
  result_t out_data_o;

  sliding_window_range_spread uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // samples waiting to be sent and spreads waiting to come out
  item_t   frame_q  [$];
  result_t spread_q [$];

  // predictor state: sample history newest first, counts and register copy
  shortint          hist [Depth];
  int               rcvd_cnt   = 0;
  int               pend_cnt   = 0;
  logic [HalfW-1:0] half_width = HalfWidthRst;
  logic [FracW-1:0] frac_part  = '0;

  int  fails = 0;
  int  n_items = 0;
  int  n_results = 0;
  int  n_settings = 0;
  int  cycles = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  bit  in_took = 1'b0;
  bit  calm = 1'b0;

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // range and position gap of the window around the sample lag steps back
  function automatic result_t spread_at(int lag, bit last);
    longint  one, v, a, b, mn, mx, pmn, pmx, off, rng, gap;
    int      h, f, left, lo, hi, k;
    bit      first;
    result_t r;
    one = longint'(1) << FracBitsDef;
    h = half_width;
    f = frac_part;
    left = (rcvd_cnt > lag) ? rcvd_cnt - 1 - lag : 0;
    lo = (h < left) ? h : left;
    hi = (h < lag) ? h : lag;
    first = 1'b1;
    mn = 0; mx = 0; pmn = 0; pmx = 0;
    // plain samples, strict compares keep the first tie
    for (k = -lo; k <= hi; k++) begin
      v = longint'(hist[lag - k]) * one;
      if (first || v < mn) begin
        mn = v;
        pmn = k * one;
      end
      if (first || v > mx) begin
        mx = v;
        pmx = k * one;
      end
      first = 1'b0;
    end
    // interpolated points just past the integer window
    if (f != 0) begin
      off = h * one + f;
      if (h + 1 <= left) begin
        a = hist[lag + h];
        b = hist[lag + h + 1];
        v = a * one + (b - a) * f;
        if (v < mn) begin
          mn = v;
          pmn = -off;
        end else if (v > mx) begin
          mx = v;
          pmx = -off;
        end
      end
      if (h + 1 <= lag) begin
        a = hist[lag - h];
        b = hist[lag - h - 1];
        v = a * one + (b - a) * f;
        if (v < mn) begin
          mn = v;
          pmn = off;
        end else if (v > mx) begin
          mx = v;
          pmx = off;
        end
      end
    end
    rng = mx - mn;
    if (rng > 64'hFFFFFF) rng = 64'hFFFFFF;
    gap = pmx - pmn;
    if (gap < 0) gap = -gap;
    if (gap > 64'h7FFF) gap = 64'h7FFF;
    r.range_value  = rng[RangeW-1:0];
    r.position_gap = gap[GapW-1:0];
    r.result_last  = last;
    return r;
  endfunction

  // take one sample into the history and queue the spreads it releases
  task automatic predict_item(item_t it);
    int hold;
    hold = half_width + ((frac_part != 0) ? 1 : 0);
    if (hold > PendCap) hold = PendCap;
    for (int i = Depth - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = it.sample;
    if (rcvd_cnt < CountCap) rcvd_cnt++;
    if (pend_cnt < PendCap + 1) pend_cnt++;
    if (it.frame_last) begin
      while (pend_cnt > 0) begin
        spread_q.push_back(spread_at(pend_cnt - 1, pend_cnt == 1));
        pend_cnt--;
      end
      rcvd_cnt = 0;
    end else begin
      while (pend_cnt > hold) begin
        spread_q.push_back(spread_at(pend_cnt - 1, 1'b0));
        pend_cnt--;
      end
    end
  endtask

  task automatic check_field(string name, logic [RangeW-1:0] want, logic [RangeW-1:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // input driver: holds an item until taken, idles in random bursts
  always @(negedge clk_i) begin : feed
    logic  nv;
    item_t nd;
    nv = in_valid_i;
    nd = in_data_i;
    if (!in_valid_i || in_took) begin
      nv = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(1, 7) - 1;
      end else if (frame_q.size() != 0) begin
        nv = 1'b1;
        nd = frame_q.pop_front();
      end
    end
    in_valid_i <= nv;
    in_data_i  <= nd;
  end

  // output stalls in random bursts
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // check results, then predict from the item taken at this edge
  always @(posedge clk_i) begin : watch
    result_t due;
    in_took <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (spread_q.size() == 0) begin
          fails++;
          $display("%0t: result with nothing expected, expected none got %h",
                   $time, out_data_o);
        end else begin
          due = spread_q.pop_front();
          check_field("range_value", due.range_value, out_data_o.range_value);
          check_field("position_gap", RangeW'(due.position_gap),
                      RangeW'(out_data_o.position_gap));
          check_field("result_last", RangeW'(due.result_last),
                      RangeW'(out_data_o.result_last));
          n_results++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_item(in_data_i);
        n_items++;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // wait until every item is sent and every spread has come out
  task automatic settle();
    while (frame_q.size() != 0 || in_valid_i || spread_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_HALF_WIDTH) half_width = val[HalfW-1:0];
    else frac_part = val[FracW-1:0];
  endtask

  task automatic set_window(int h, int f);
    settle();
    write_reg(CFG_HALF_WIDTH, CfgW'(h));
    write_reg(CFG_FRAC_PART, CfgW'(f));
    n_settings++;
  endtask

  task automatic push_item(shortint s, bit last);
    item_t it;
    it.sample = s;
    it.frame_last = last;
    frame_q.push_back(it);
  endtask

  // extremes, small values that tie, or anything
  function automatic shortint pick_sample();
    case ($urandom_range(0, 7))
      0: return shortint'(-32768);
      1: return shortint'(32767);
      2, 3: return shortint'(int'($urandom_range(0, 6)) - 3);
      default: return shortint'($urandom);
    endcase
  endfunction

  task automatic push_frame(int len);
    for (int i = 0; i < len; i++) push_item(pick_sample(), i == len - 1);
  endtask

  // stimulus
  initial begin : stim
    int h, f, len, sent;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset window: one-sample frame, full-scale step, flat frame
    push_item(32767, 1'b1);
    push_item(-32768, 1'b0);
    push_item(32767, 1'b1);
    push_item(5, 1'b0);
    push_item(5, 1'b0);
    push_item(5, 1'b0);
    push_item(5, 1'b1);

    // zero half width
    set_window(0, 0);
    push_item(0, 1'b0);
    push_item(-1, 1'b0);
    push_item(1, 1'b1);

    // shrink the window mid-frame so one item releases several spreads
    set_window(3, 0);
    push_item(-32768, 1'b0);
    push_item(200, 1'b0);
    settle();
    write_reg(CFG_HALF_WIDTH, CfgW'(0));
    push_item(-7, 1'b0);
    push_item(32767, 1'b1);

    // fraction at its top with full-scale swings
    set_window(2, 255);
    push_item(32767, 1'b0);
    push_item(-32768, 1'b0);
    push_item(100, 1'b0);
    push_item(-100, 1'b0);
    push_item(32767, 1'b0);
    push_item(-32768, 1'b1);

    // widest window with the smallest fraction
    set_window(31, 1);
    push_frame(5);

    // random frames over a spread of window settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin h = 31; f = $urandom_range(1, 255); end
        1: begin h = 0;  f = 0; end
        2: begin h = $urandom_range(1, 6); f = 0; end
        3: begin h = $urandom_range(1, 6); f = $urandom_range(1, 255); end
        4: begin h = 31; f = 0; end
        5: begin h = 0;  f = 255; end
        default: begin
          h = $urandom_range(0, 10);
          f = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 255) : 0;
        end
      endcase
      set_window(h, f);
      calm = (p == 7);
      sent = 0;
      // the widest window with a fraction gets one long frame
      if (p == 0) begin
        push_frame(40);
        sent = 40;
      end
      while (sent < 12) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
        push_frame(len);
        sent += len;
      end
    end
    settle();

    $display("%0d samples in %0d window settings, %0d spreads checked",
             n_items, n_settings, n_results);
    $display("covered flat and full-scale frames, mid-frame window change, fractions 1 to 255");
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sliding_window_range_spread.f =====
hw/rtl/swrs_pkg.sv
hw/rtl/swrs_front.sv
hw/rtl/swrs_queue.sv
hw/rtl/swrs_back.sv
hw/rtl/sliding_window_range_spread.sv
tb/sv/tb.sv
